@@ hdl/dtg_pkg.sv @@
// shared types, constants and table functions of the dtmf and ringback tone generator
package dtg_pkg;

   // audio timing and quarter-wave table geometry
   localparam int unsigned SAMPLE_RATE  = 8000;
   localparam int unsigned QTAB_DEPTH   = 2001;
   localparam int unsigned QUARTER      = SAMPLE_RATE / 4;
   localparam int unsigned PHASE_W      = $clog2(SAMPLE_RATE);
   localparam int unsigned QADDR_W      = $clog2(QTAB_DEPTH);

   // field and register widths
   localparam int unsigned SAMPLE_W     = 16;
   localparam int unsigned AMP_W        = 14;
   localparam int unsigned LEN_W        = 16;
   localparam int unsigned HZ_W         = 11;
   localparam int unsigned PROD_W       = SAMPLE_W + AMP_W;

   // register reset values
   localparam logic [AMP_W-1:0] AMP_RESET = AMP_W'(7000);
   localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(800);

   // ringback cadence in samples
   localparam logic [3:0]       RINGBACK_SEL = 4'd12;
   localparam logic [LEN_W-1:0] RB_ON        = LEN_W'(3200);
   localparam logic [LEN_W-1:0] RB_GAP       = LEN_W'(1600);
   localparam logic [LEN_W-1:0] RB_OFF       = LEN_W'(16000);
   localparam logic [LEN_W-1:0] RB_TOTAL     = RB_ON + RB_GAP + RB_ON + RB_OFF;
   localparam logic [HZ_W-1:0]  RB_LOW_HZ    = HZ_W'(400);
   localparam logic [HZ_W-1:0]  RB_HIGH_HZ   = HZ_W'(450);

   // fixed point constants for the table build
   localparam logic [63:0] ONE_Q30 = 64'd1073741824;
   localparam logic [63:0] PI_Q30  = 64'd3373259426;
   localparam int unsigned SERIES_DIV [7] = '{210, 156, 110, 72, 42, 20, 6};

   // transaction modes
   typedef enum logic [1:0] {
      MODE_TICK  = 2'd0,
      MODE_START = 2'd1,
      MODE_STOP  = 2'd2,
      MODE_HOLD  = 2'd3
   } mode_type;

   // configuration register indexes
   typedef enum logic {
      CSR_AMPLITUDE   = 1'b0,
      CSR_DTMF_LENGTH = 1'b1
   } csr_index_type;

   // one result transaction
   typedef struct packed {
      logic signed [SAMPLE_W-1:0] sample;
      logic                       active;
      logic                       tone_end;
   } result_type;

   typedef logic [SAMPLE_W-1:0] sine_rom_type [QTAB_DEPTH];

   // row frequency of a key, ringback low tone otherwise
   function automatic logic [HZ_W-1:0] row_hz(input logic [3:0] tone);
      logic [HZ_W-1:0] hz;
      case (tone) inside
         4'd1, 4'd2, 4'd3:    hz = HZ_W'(697);
         4'd4, 4'd5, 4'd6:    hz = HZ_W'(770);
         4'd7, 4'd8, 4'd9:    hz = HZ_W'(852);
         4'd0, 4'd10, 4'd11:  hz = HZ_W'(941);
         default:             hz = RB_LOW_HZ;
      endcase
      return hz;
   endfunction

   // column frequency of a key, ringback high tone otherwise
   function automatic logic [HZ_W-1:0] col_hz(input logic [3:0] tone);
      logic [HZ_W-1:0] hz;
      case (tone) inside
         4'd1, 4'd4, 4'd7, 4'd10: hz = HZ_W'(1209);
         4'd0, 4'd2, 4'd5, 4'd8:  hz = HZ_W'(1336);
         4'd3, 4'd6, 4'd9, 4'd11: hz = HZ_W'(1477);
         default:                 hz = RB_HIGH_HZ;
      endcase
      return hz;
   endfunction

   // phase step modulo one period
   function automatic logic [PHASE_W-1:0] advance_phase(input logic [PHASE_W-1:0] p,
                                                        input logic [HZ_W-1:0] hz);
      logic [PHASE_W:0] sum;
      sum = (PHASE_W+1)'(p) + (PHASE_W+1)'(hz);
      if (sum >= (PHASE_W+1)'(SAMPLE_RATE)) begin
         sum = sum - (PHASE_W+1)'(SAMPLE_RATE);
      end
      return sum[PHASE_W-1:0];
   endfunction

   // fold a phase onto the quarter-wave table
   function automatic logic [QADDR_W-1:0] quarter_index(input logic [PHASE_W-1:0] p);
      logic [PHASE_W-1:0] idx;
      if (p <= PHASE_W'(QUARTER)) begin
         idx = p;
      end else if (p <= PHASE_W'(2 * QUARTER)) begin
         idx = PHASE_W'(2 * QUARTER) - p;
      end else if (p <= PHASE_W'(3 * QUARTER)) begin
         idx = p - PHASE_W'(2 * QUARTER);
      end else begin
         idx = PHASE_W'(SAMPLE_RATE) - p;
      end
      return idx[QADDR_W-1:0];
   endfunction

   // one table entry: taylor series of the sine in q30, rounded to q15
   function automatic logic [SAMPLE_W-1:0] sine_entry(input int unsigned i);
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] t;
      logic [63:0] s;
      logic [63:0] v;
      x = (64'(i) * PI_Q30 + 64'd2000) / 64'd4000;
      x2 = (x * x) >> 30;
      t = ONE_Q30;
      for (int k = 0; k < 7; k++) begin
         t = ONE_Q30 - ((x2 * t) >> 30) / 64'(SERIES_DIV[k]);
      end
      s = (x * t) >> 30;
      v = (s * 64'd32767 + (ONE_Q30 >> 1)) >> 30;
      return (v > 64'd32767) ? SAMPLE_W'(32767) : v[SAMPLE_W-1:0];
   endfunction

   // whole quarter-wave table, built at elaboration
   function automatic sine_rom_type build_sine_rom();
      sine_rom_type rom;
      for (int unsigned i = 0; i < QTAB_DEPTH; i++) begin
         rom[i] = sine_entry(i);
      end
      return rom;
   endfunction

endpackage

@@ hdl/dtg_sine_rom.sv @@
// quarter-wave sine rom with two registered read ports
module dtg_sine_rom (
   input  logic                          clock,
   input  logic [dtg_pkg::QADDR_W-1:0]   addr_a,
   input  logic [dtg_pkg::QADDR_W-1:0]   addr_b,
   output logic [dtg_pkg::SAMPLE_W-1:0]  data_a,
   output logic [dtg_pkg::SAMPLE_W-1:0]  data_b
);
   import dtg_pkg::*;

   localparam sine_rom_type SINE_ROM = build_sine_rom();

   logic [SAMPLE_W-1:0] data_a_ff;
   logic [SAMPLE_W-1:0] data_b_ff;

   // registered reads
   always_ff @(posedge clock) begin
      data_a_ff <= SINE_ROM[addr_a];
      data_b_ff <= SINE_ROM[addr_b];
   end

   assign data_a = data_a_ff;
   assign data_b = data_b_ff;

endmodule

@@ hdl/dtg_tone_core.sv @@
// tone state, configuration registers and per-transaction sample logic
module dtg_tone_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          accept,
   input  logic [1:0]                    mode,
   input  logic [3:0]                    tone_select,
   input  logic                          loop_enable,
   input  logic                          csr_write_enable,
   input  logic                          csr_index,
   input  logic [dtg_pkg::LEN_W-1:0]     csr_write_data,
   output logic [dtg_pkg::QADDR_W-1:0]   rom_lo_addr,
   output logic [dtg_pkg::QADDR_W-1:0]   rom_hi_addr,
   input  logic [dtg_pkg::SAMPLE_W-1:0]  rom_lo_data,
   input  logic [dtg_pkg::SAMPLE_W-1:0]  rom_hi_data,
   output dtg_pkg::result_type           result
);
   import dtg_pkg::*;

   logic [PHASE_W-1:0] phase_lo_ff, phase_lo_in;
   logic [PHASE_W-1:0] phase_hi_ff, phase_hi_in;
   logic [LEN_W-1:0]   pos_ff, pos_in;
   logic [3:0]         tone_ff, tone_in;
   logic               loop_ff, loop_in;
   logic               play_ff, play_in;
   logic [AMP_W-1:0]   amp_ff;
   logic [LEN_W-1:0]   len_ff;

   logic               ringback;
   logic [LEN_W-1:0]   tone_len;
   logic               tone_on;
   logic               last_sample;
   logic               neg_lo, neg_hi;
   logic [PROD_W-1:0]  prod_lo, prod_hi;
   logic [SAMPLE_W:0]  term_lo, term_hi, term_sum;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         amp_ff <= AMP_RESET;
         len_ff <= LEN_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index_type'(csr_index))
            CSR_AMPLITUDE:   amp_ff <= csr_write_data[AMP_W-1:0];
            CSR_DTMF_LENGTH: len_ff <= csr_write_data;
         endcase
      end
   end

   // tone shape for the current position
   assign ringback    = (tone_ff == RINGBACK_SEL);
   assign tone_len    = ringback ? RB_TOTAL : ((len_ff == '0) ? LEN_W'(1) : len_ff);
   assign tone_on     = !ringback || (pos_ff < RB_ON) ||
                        ((pos_ff >= RB_ON + RB_GAP) && (pos_ff < RB_ON + RB_GAP + RB_ON));
   assign last_sample = ((LEN_W+1)'(pos_ff) + (LEN_W+1)'(1)) >= (LEN_W+1)'(tone_len);

   // scaled sine terms, truncated toward zero, summed with 16-bit wrap
   assign neg_lo   = phase_lo_ff > PHASE_W'(2 * QUARTER);
   assign neg_hi   = phase_hi_ff > PHASE_W'(2 * QUARTER);
   assign prod_lo  = PROD_W'(rom_lo_data) * PROD_W'(amp_ff);
   assign prod_hi  = PROD_W'(rom_hi_data) * PROD_W'(amp_ff);
   assign term_lo  = neg_lo ? ((SAMPLE_W+1)'(0) - (SAMPLE_W+1)'(prod_lo[PROD_W-1:15]))
                            : (SAMPLE_W+1)'(prod_lo[PROD_W-1:15]);
   assign term_hi  = neg_hi ? ((SAMPLE_W+1)'(0) - (SAMPLE_W+1)'(prod_hi[PROD_W-1:15]))
                            : (SAMPLE_W+1)'(prod_hi[PROD_W-1:15]);
   assign term_sum = term_lo + term_hi;

   // next state and result of an accepted transaction
   always_comb begin
      phase_lo_in     = phase_lo_ff;
      phase_hi_in     = phase_hi_ff;
      pos_in          = pos_ff;
      tone_in         = tone_ff;
      loop_in         = loop_ff;
      play_in         = play_ff;
      result.sample   = '0;
      result.active   = play_ff;
      result.tone_end = 1'b0;
      if (accept) begin
         unique case (mode_type'(mode))
            MODE_TICK: begin
               if (play_ff) begin
                  result.active = 1'b1;
                  if (tone_on) begin
                     result.sample = signed'(term_sum[SAMPLE_W-1:0]);
                     phase_lo_in   = advance_phase(phase_lo_ff, row_hz(tone_ff));
                     phase_hi_in   = advance_phase(phase_hi_ff, col_hz(tone_ff));
                  end else begin
                     phase_lo_in = '0;
                     phase_hi_in = '0;
                  end
                  if (last_sample) begin
                     pos_in      = '0;
                     phase_lo_in = '0;
                     phase_hi_in = '0;
                     if (!loop_ff) begin
                        play_in         = 1'b0;
                        result.tone_end = 1'b1;
                     end
                  end else begin
                     pos_in = pos_ff + LEN_W'(1);
                  end
               end
            end
            MODE_START: begin
               if (tone_select <= RINGBACK_SEL) begin
                  tone_in       = tone_select;
                  loop_in       = loop_enable;
                  play_in       = 1'b1;
                  pos_in        = '0;
                  phase_lo_in   = '0;
                  phase_hi_in   = '0;
                  result.active = 1'b1;
               end
            end
            MODE_STOP: begin
               play_in       = 1'b0;
               pos_in        = '0;
               phase_lo_in   = '0;
               phase_hi_in   = '0;
               result.active = 1'b0;
            end
            MODE_HOLD: begin
               play_in = play_ff;
            end
         endcase
      end
   end

   // rom is addressed from the next phase so its data lines up with the phase registers
   assign rom_lo_addr = reset ? '0 : quarter_index(phase_lo_in);
   assign rom_hi_addr = reset ? '0 : quarter_index(phase_hi_in);

   // tone state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_lo_ff <= '0;
         phase_hi_ff <= '0;
         pos_ff      <= '0;
         tone_ff     <= '0;
         loop_ff     <= 1'b0;
         play_ff     <= 1'b0;
      end else begin
         phase_lo_ff <= phase_lo_in;
         phase_hi_ff <= phase_hi_in;
         pos_ff      <= pos_in;
         tone_ff     <= tone_in;
         loop_ff     <= loop_in;
         play_ff     <= play_in;
      end
   end

endmodule

@@ hdl/dtg_out_buf.sv @@
// result register and skid stage; a stalled result still takes one more input
module dtg_out_buf (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  dtg_pkg::result_type  in_data,
   output logic                 in_stall,
   output logic                 out_valid,
   input  logic                 out_stall,
   output dtg_pkg::result_type  out_data
);
   import dtg_pkg::*;

   logic       out_valid_ff;
   logic       skid_valid_ff;
   result_type out_data_ff;
   result_type skid_data_ff;
   logic       push;
   logic       pop;

   assign in_stall = skid_valid_ff;
   assign push     = in_valid && !skid_valid_ff;
   assign pop      = out_valid_ff && !out_stall;

   // occupancy
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (!out_valid_ff || pop) begin
         out_valid_ff  <= skid_valid_ff || push;
         skid_valid_ff <= 1'b0;
      end else if (push) begin
         skid_valid_ff <= 1'b1;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (!out_valid_ff || pop) begin
         out_data_ff <= skid_valid_ff ? skid_data_ff : in_data;
      end else if (push) begin
         skid_data_ff <= in_data;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;

endmodule

@@ hdl/dtmf_ringback_tone_generator_top.sv @@
// top level of the dtmf and ringback tone generator
//
//   port group   direction   handshake            payload
//   req_         in          req_valid/req_stall  mode, tone_select, loop_enable
//   rsp_         out         rsp_valid/rsp_stall  sample, active, tone_end
//   csr_         in          csr_write_enable     csr_index, csr_write_data
//
// one transaction per cycle while req_stall is low; each result is registered at accept
// the sine rom is read from the next phase, so its registered data is ready at the tick
// reset is synchronous; no clearing pass, the rom is constant
// a two-entry output stage takes one more transaction while a result is stalled,
// then req_stall rises until the output drains
module dtmf_ringback_tone_generator_top (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [1:0]                   req_mode,
   input  logic [3:0]                   req_tone_select,
   input  logic                         req_loop_enable,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic signed [15:0]           rsp_sample,
   output logic                         rsp_active,
   output logic                         rsp_tone_end,
   input  logic                         csr_write_enable,
   input  logic                         csr_index,
   input  logic [dtg_pkg::LEN_W-1:0]    csr_write_data
);
   import dtg_pkg::*;

   logic [QADDR_W-1:0]  rom_lo_addr, rom_hi_addr;
   logic [SAMPLE_W-1:0] rom_lo_data, rom_hi_data;
   logic                req_accept;
   result_type          core_result;
   result_type          rsp_result;

   assign req_accept = req_valid && !req_stall;

   // tone state and sample arithmetic
   dtg_tone_core u_core (
      .clock            (clock),
      .reset            (reset),
      .accept           (req_accept),
      .mode             (req_mode),
      .tone_select      (req_tone_select),
      .loop_enable      (req_loop_enable),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .rom_lo_addr      (rom_lo_addr),
      .rom_hi_addr      (rom_hi_addr),
      .rom_lo_data      (rom_lo_data),
      .rom_hi_data      (rom_hi_data),
      .result           (core_result)
   );

   // quarter-wave table
   dtg_sine_rom u_rom (
      .clock  (clock),
      .addr_a (rom_lo_addr),
      .addr_b (rom_hi_addr),
      .data_a (rom_lo_data),
      .data_b (rom_hi_data)
   );

   // result register and skid stage
   dtg_out_buf u_out (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_accept),
      .in_data   (core_result),
      .in_stall  (req_stall),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_data  (rsp_result)
   );

   assign rsp_sample   = rsp_result.sample;
   assign rsp_active   = rsp_result.active;
   assign rsp_tone_end = rsp_result.tone_end;

endmodule

@@ hdl/dtg_checker.sv @@
// port-level checks of the tone generator, bound to the top level
module dtg_checker (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   input  logic                         req_stall,
   input  logic [1:0]                   req_mode,
   input  logic [3:0]                   req_tone_select,
   input  logic                         req_loop_enable,
   input  logic                         rsp_valid,
   input  logic                         rsp_stall,
   input  logic signed [15:0]           rsp_sample,
   input  logic                         rsp_active,
   input  logic                         rsp_tone_end,
   input  logic                         csr_write_enable,
   input  logic                         csr_index,
   input  logic [dtg_pkg::LEN_W-1:0]    csr_write_data
);
   import dtg_pkg::*;

   // reset empties the output stage
   assert property (@(posedge clock) reset |=> !rsp_valid && !req_stall)
      else $error("output stage not empty after reset");

   // input is only held off while a result is waiting
   assert property (@(posedge clock) disable iff (reset) req_stall |-> rsp_valid)
      else $error("input stalled with no result pending");

   // a stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_sample) &&
                                 $stable(rsp_active) && $stable(rsp_tone_end))
      else $error("stalled result changed");

   // end of tone only comes with a played sample
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_tone_end |-> rsp_active)
      else $error("tone end without active");

   // sound only while a tone is active
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_sample != 16'sd0) |-> rsp_active)
      else $error("non-zero sample while idle");

endmodule

bind dtmf_ringback_tone_generator_top dtg_checker u_checker (.*);

@@ tb/tone_checker.sv @@
// transaction monitor, sample predictor and result comparison for the tone generator
module tone_checker (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   input  logic                        req_stall,
   input  logic [1:0]                  req_mode,
   input  logic [3:0]                  req_tone_select,
   input  logic                        req_loop_enable,
   input  logic                        rsp_valid,
   input  logic                        rsp_stall,
   input  logic signed [15:0]          rsp_sample,
   input  logic                        rsp_active,
   input  logic                        rsp_tone_end,
   input  logic                        csr_write_enable,
   input  logic                        csr_index,
   input  logic [dtg_pkg::LEN_W-1:0]   csr_write_data,
   output int                          fail_total,
   output int                          results_pending
);
   timeunit 1ns;
   timeprecision 1ps;
   import dtg_pkg::*;

   // keypad frequencies, indexed by key code
   localparam int unsigned KEY_ROW_HZ [12] = '{941, 697, 697, 697, 770, 770, 770,
                                               852, 852, 852, 941, 941};
   localparam int unsigned KEY_COL_HZ [12] = '{1336, 1209, 1336, 1477, 1209, 1336,
                                               1477, 1209, 1336, 1477, 1209, 1477};

   // ringback cadence boundaries
   localparam int unsigned FIRST_ON_END  = RB_ON;
   localparam int unsigned SECOND_ON_BEG = RB_ON + RB_GAP;
   localparam int unsigned SECOND_ON_END = RB_ON + RB_GAP + RB_ON;

   logic [15:0]  qsine [QTAB_DEPTH];
   int unsigned  amplitude;
   int unsigned  burst_len;
   int unsigned  phase_row;
   int unsigned  phase_col;
   int unsigned  position;
   logic [3:0]   tone;
   logic         looping;
   logic         playing;
   int           mismatch_count;
   result_type   samples_due [$];

   // quarter-wave sine entry from the q30 taylor series, rounded to q15
   function automatic logic [15:0] quarter_sine(input int unsigned i);
      logic [63:0] ang;
      logic [63:0] ang_sq;
      logic [63:0] acc;
      logic [63:0] q15;
      ang = (64'(i) * PI_Q30 + 64'd2000) / 64'd4000;
      ang_sq = (ang * ang) >> 30;
      acc = ONE_Q30;
      for (int k = 0; k < 7; k++) begin
         acc = ONE_Q30 - ((ang_sq * acc) >> 30) / 64'(SERIES_DIV[k]);
      end
      acc = (ang * acc) >> 30;
      q15 = (acc * 64'd32767 + (ONE_Q30 >> 1)) >> 30;
      return (q15 > 64'd32767) ? 16'd32767 : q15[15:0];
   endfunction

   // one scaled sine component, truncated toward zero
   function automatic int sine_term(input int unsigned ph);
      int unsigned p;
      int unsigned idx;
      int unsigned mag;
      logic        neg;
      p = ph % SAMPLE_RATE;
      neg = 1'b0;
      if (p <= QUARTER) begin
         idx = p;
      end else if (p <= 2 * QUARTER) begin
         idx = 2 * QUARTER - p;
      end else if (p <= 3 * QUARTER) begin
         idx = p - 2 * QUARTER;
         neg = 1'b1;
      end else begin
         idx = SAMPLE_RATE - p;
         neg = 1'b1;
      end
      mag = (32'(qsine[idx]) * amplitude) >> 15;
      return neg ? -int'(mag) : int'(mag);
   endfunction

   function automatic void rewind();
      position = 0;
      phase_row = 0;
      phase_col = 0;
   endfunction

   // advance the tone state by one transaction and return the result it gives
   function automatic result_type next_sample(input mode_type m, input logic [3:0] sel,
                                              input logic lp);
      result_type  r;
      int unsigned span;
      int unsigned f_row;
      int unsigned f_col;
      logic        audible;
      int          level;
      level = 0;
      r.active = playing;
      r.tone_end = 1'b0;
      case (m)
         MODE_START: begin
            if (sel <= RINGBACK_SEL) begin
               tone = sel;
               looping = lp;
               playing = 1'b1;
               rewind();
            end
            r.active = playing;
         end
         MODE_STOP: begin
            playing = 1'b0;
            rewind();
            r.active = 1'b0;
         end
         MODE_TICK: begin
            if (playing) begin
               if (tone >= RINGBACK_SEL) begin
                  span = RB_TOTAL;
                  f_row = RB_LOW_HZ;
                  f_col = RB_HIGH_HZ;
                  audible = position < FIRST_ON_END ||
                            (position >= SECOND_ON_BEG && position < SECOND_ON_END);
               end else begin
                  span = (burst_len == 0) ? 1 : burst_len;
                  f_row = KEY_ROW_HZ[tone];
                  f_col = KEY_COL_HZ[tone];
                  audible = 1'b1;
               end
               // silent stretches of ringback hold both phases at zero
               if (audible) begin
                  level = sine_term(phase_row) + sine_term(phase_col);
                  phase_row = (phase_row + f_row) % SAMPLE_RATE;
                  phase_col = (phase_col + f_col) % SAMPLE_RATE;
               end else begin
                  phase_row = 0;
                  phase_col = 0;
               end
               r.active = 1'b1;
               if (position + 1 >= span) begin
                  rewind();
                  if (!looping) begin
                     playing = 1'b0;
                     r.tone_end = 1'b1;
                  end
               end else begin
                  position = position + 1;
               end
            end else begin
               r.active = 1'b0;
            end
         end
         default: ;
      endcase
      r.sample = level[15:0];
      return r;
   endfunction

   // sine rom image
   initial begin
      for (int unsigned i = 0; i < QTAB_DEPTH; i++) begin
         qsine[i] = quarter_sine(i);
      end
   end

   // register writes, accepted transactions and result comparison
   always @(posedge clock) begin
      result_type want;
      result_type got;
      if (reset) begin
         amplitude = AMP_RESET;
         burst_len = LEN_RESET;
         tone = '0;
         looping = 1'b0;
         playing = 1'b0;
         rewind();
         samples_due.delete();
      end else begin
         if (csr_write_enable) begin
            case (csr_index_type'(csr_index))
               CSR_AMPLITUDE:   amplitude = csr_write_data[AMP_W-1:0];
               CSR_DTMF_LENGTH: burst_len = csr_write_data;
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            samples_due.push_back(next_sample(mode_type'(req_mode), req_tone_select,
                                              req_loop_enable));
         end
         if (rsp_valid && !rsp_stall) begin
            got.sample = rsp_sample;
            got.active = rsp_active;
            got.tone_end = rsp_tone_end;
            if (samples_due.size() == 0) begin
               if (mismatch_count < 10) begin
                  $display("%0t tone_checker: unexpected result sample %0d active %b end %b",
                           $realtime, got.sample, got.active, got.tone_end);
               end
               mismatch_count++;
            end else begin
               want = samples_due.pop_front();
               if (got.sample !== want.sample || got.active !== want.active ||
                   got.tone_end !== want.tone_end) begin
                  if (mismatch_count < 10) begin
                     $display("%0t tone_checker: expected sample %0d active %b end %b, %s %0d %b %b",
                              $realtime, want.sample, want.active, want.tone_end, "got",
                              got.sample, got.active, got.tone_end);
                  end
                  mismatch_count++;
               end
            end
         end
      end
      fail_total <= mismatch_count;
      results_pending <= samples_due.size();
   end

   initial mismatch_count = 0;

endmodule

@@ tb/testbench.sv @@
// stimulus, clock, reset and verdict for the dtmf and ringback tone generator
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import dtg_pkg::*;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_stall;
   logic [1:0]           req_mode;
   logic [3:0]           req_tone_select;
   logic                 req_loop_enable;
   logic                 rsp_valid;
   logic                 rsp_stall;
   logic signed [15:0]   rsp_sample;
   logic                 rsp_active;
   logic                 rsp_tone_end;
   logic                 csr_write_enable;
   logic                 csr_index;
   logic [LEN_W-1:0]     csr_write_data;
   int                   fail_total;
   int                   results_pending;
   bit                   idle_on;
   bit                   stall_on;

   dtmf_ringback_tone_generator_top dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_mode         (req_mode),
      .req_tone_select  (req_tone_select),
      .req_loop_enable  (req_loop_enable),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_sample       (rsp_sample),
      .rsp_active       (rsp_active),
      .rsp_tone_end     (rsp_tone_end),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   tone_checker tone_check (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_mode         (req_mode),
      .req_tone_select  (req_tone_select),
      .req_loop_enable  (req_loop_enable),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_sample       (rsp_sample),
      .rsp_active       (rsp_active),
      .rsp_tone_end     (rsp_tone_end),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .fail_total       (fail_total),
      .results_pending  (results_pending)
   );

   // 4 ns clock
   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   // result side back-pressure in random bursts
   initial begin
      int burst;
      burst = 0;
      rsp_stall = 1'b0;
      forever begin
         @(posedge clock);
         if (burst > 0) begin
            burst--;
         end else if (stall_on && $urandom_range(0, 5) == 0) begin
            burst = $urandom_range(1, 4);
         end
         rsp_stall <= (burst > 0);
      end
   end

   // hard stop
   initial begin
      #10_000_000;
      $display("tb: failure");
      $finish;
   end

   // one transaction, with an occasional gap in front of it
   task automatic send_item(input mode_type m, input logic [3:0] sel, input logic lp);
      int gap;
      if (idle_on && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 4);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_mode <= m;
      req_tone_select <= sel;
      req_loop_enable <= lp;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // tick with don't-care select and loop fields
   task automatic send_ticks(input int n);
      repeat (n) send_item(MODE_TICK, 4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
   endtask

   // stop sending and wait for every outstanding result
   task automatic settle();
      req_valid <= 1'b0;
      do @(posedge clock); while (results_pending != 0);
      repeat (4) @(posedge clock);
   endtask

   // write both registers back to back
   task automatic load_regs(input int amp, input int len);
      csr_write_enable <= 1'b1;
      csr_index <= CSR_AMPLITUDE;
      csr_write_data <= LEN_W'(amp);
      @(posedge clock);
      csr_index <= CSR_DTMF_LENGTH;
      csr_write_data <= LEN_W'(len);
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   initial begin
      int amp_pick;
      int len_pick;
      int sent;
      int ticks;
      req_valid = 1'b0;
      req_mode = MODE_TICK;
      req_tone_select = '0;
      req_loop_enable = 1'b0;
      csr_write_enable = 1'b0;
      csr_index = CSR_AMPLITUDE;
      csr_write_data = '0;
      idle_on = 1'b1;
      stall_on = 1'b1;
      reset = 1'b1;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // idle behaviour, bad selects, restart while playing, stop
      send_item(MODE_TICK, 4'd0, 1'b0);
      send_item(MODE_HOLD, 4'd3, 1'b1);
      send_item(MODE_START, 4'd15, 1'b1);
      send_item(MODE_START, 4'd13, 1'b0);
      send_item(MODE_START, 4'd1, 1'b0);
      send_ticks(3);
      send_item(MODE_HOLD, 4'd0, 1'b0);
      send_item(MODE_START, RINGBACK_SEL, 1'b1);
      send_ticks(2);
      send_item(MODE_STOP, 4'd7, 1'b1);
      send_item(MODE_TICK, 4'd0, 1'b0);

      // full amplitude, zero length acts as one sample
      settle();
      load_regs(16383, 0);
      send_item(MODE_START, 4'd11, 1'b0);
      send_ticks(2);
      send_item(MODE_START, 4'd0, 1'b1);
      send_ticks(2);

      // length cut below the current position ends the tone on the next tick
      settle();
      load_regs(0, 65535);
      send_item(MODE_START, 4'd10, 1'b0);
      send_ticks(3);
      settle();
      load_regs(5000, 2);
      send_ticks(2);

      // random phases of start and tick runs with some noise
      for (int ph = 0; ph < 12; ph++) begin
         settle();
         case ($urandom_range(0, 3))
            0:       amp_pick = 0;
            1:       amp_pick = 16383;
            default: amp_pick = $urandom_range(0, 16383);
         endcase
         case ($urandom_range(0, 5))
            0:       len_pick = 65535;
            1:       len_pick = $urandom_range(1, 65535);
            2:       len_pick = 1;
            default: len_pick = $urandom_range(2, 40);
         endcase
         load_regs(amp_pick, len_pick);
         idle_on = (ph % 3 != 2);
         stall_on = (ph % 4 != 3);
         sent = 0;
         while (sent < 75) begin
            if ($urandom_range(0, 4) == 0) begin
               send_item(mode_type'($urandom_range(0, 3)), 4'($urandom_range(0, 15)),
                         1'($urandom_range(0, 1)));
               sent++;
            end else begin
               send_item(MODE_START, 4'($urandom_range(0, 12)), 1'($urandom_range(0, 1)));
               ticks = $urandom_range(1, 50);
               send_ticks(ticks);
               sent += ticks + 1;
            end
         end
      end

      // ringback from its start, then looping ringback cut short by a stop
      settle();
      load_regs($urandom_range(1, 16383), $urandom_range(1, 65535));
      idle_on = 1'b1;
      stall_on = 1'b1;
      send_item(MODE_START, RINGBACK_SEL, 1'b0);
      send_ticks(60);
      idle_on = 1'b0;
      stall_on = 1'b0;
      send_item(MODE_START, RINGBACK_SEL, 1'b1);
      send_ticks(40);
      send_item(MODE_STOP, 4'd0, 1'b0);

      // drain and give the verdict
      settle();
      repeat (8) @(posedge clock);
      if (fail_total == 0 && results_pending == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
